FILE: rtl/core/lswc_pkg.sv
// Package for the late supplier wait counter.
// Holds the word types of the item, result and configuration channels and the codes.
// No dependencies.
`default_nettype none

package lswc_pkg;

    localparam int KEY_BITS    = 14;
    localparam int NATION_BITS = 8;
    localparam int DATE_BITS   = 16;
    localparam int LATE_BITS   = 8;
    localparam int WAIT_BITS   = 32;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [1:0] FUNC_SUPPLIER = 2'd0;
    localparam logic [1:0] FUNC_LINE     = 2'd1;
    localparam logic [1:0] FUNC_READ     = 2'd2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_TARGET_NATION = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_SUPP_KEY  = 2'd1;

    localparam logic [KEY_BITS-1:0]  MAX_KEY_RESET = '1;
    localparam logic [LATE_BITS-1:0] LATE_MAX      = '1;

    typedef struct packed {
        logic [1:0]             func;
        logic [KEY_BITS-1:0]    supp_key;
        logic [NATION_BITS-1:0] nation_key;
        logic [DATE_BITS-1:0]   commit_date;
        logic [DATE_BITS-1:0]   receipt_date;
        logic                   order_final;
        logic                   last_line;
    } t_in_word;

    typedef struct packed {
        logic                 order_done;
        logic                 order_counted;
        logic [KEY_BITS-1:0]  late_supplier;
        logic [LATE_BITS-1:0] added_lines;
        logic [WAIT_BITS-1:0] wait_count;
        logic                 supplier_listed;
    } t_out_word;

    typedef struct packed {
        logic [CFG_IDX_BITS-1:0]  index;
        logic [CFG_DATA_BITS-1:0] data;
    } t_cfg_word;

    typedef struct packed {
        logic                 close;
        logic                 cand;
        logic [KEY_BITS-1:0]  late_key;
        logic [LATE_BITS-1:0] late_lines;
    } t_order_close;

endpackage

`default_nettype wire

FILE: rtl/core/lswc_chan_if.sv
// Valid/ready channel interface carrying one word of a chosen payload type.
// Used for the item, result and configuration channels; no dependencies.
`default_nettype none

interface lswc_chan_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/lswc_order.sv
// Per-order tracker: suppliers, late supplier and line counts of the open order.
// Depends on lswc_pkg.
`default_nettype none

module lswc_order #(
    parameter int SUPP_KEYS = 16384
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic [lswc_pkg::KEY_BITS-1:0] i_key,
    input  wire logic [lswc_pkg::KEY_BITS-1:0] i_max_key,
    input  wire logic [lswc_pkg::DATE_BITS-1:0] i_commit,
    input  wire logic [lswc_pkg::DATE_BITS-1:0] i_receipt,
    input  wire logic                          i_final,
    input  wire logic                          i_last,
    output lswc_pkg::t_order_close             o_close
);
    import lswc_pkg::*;

    localparam int AW = (SUPP_KEYS > 1) ? $clog2(SUPP_KEYS) : 1;
    localparam int KW = ((AW > KEY_BITS) ? AW : KEY_BITS) + 1;

    logic                 r_first_valid, n_first_valid;
    logic [KEY_BITS-1:0]  r_first_key, n_first_key;
    logic                 r_several, n_several;
    logic                 r_late_valid, n_late_valid;
    logic [KEY_BITS-1:0]  r_late_key, n_late_key;
    logic [LATE_BITS-1:0] r_late_lines, n_late_lines;
    logic                 r_several_late, n_several_late;
    logic [1:0]           r_lines, n_lines;

    logic                 u_first_valid;
    logic [KEY_BITS-1:0]  u_first_key;
    logic                 u_several;
    logic                 u_late_valid;
    logic [KEY_BITS-1:0]  u_late_key;
    logic [LATE_BITS-1:0] u_late_lines;
    logic                 u_several_late;
    logic [1:0]           u_lines;
    logic                 late_in_table;

    always_comb begin
        u_first_valid  = r_first_valid;
        u_first_key    = r_first_key;
        u_several      = r_several;
        u_late_valid   = r_late_valid;
        u_late_key     = r_late_key;
        u_late_lines   = r_late_lines;
        u_several_late = r_several_late;
        u_lines        = (r_lines == 2'd2) ? r_lines : r_lines + 2'd1;
        if (i_key <= i_max_key && !r_several_late) begin
            if (!r_first_valid) begin
                u_first_valid = 1'b1;
                u_first_key   = i_key;
            end else if (i_key != r_first_key) begin
                u_several = 1'b1;
            end
            if (i_receipt > i_commit) begin
                if (!r_late_valid || r_late_key == i_key) begin
                    u_late_valid = 1'b1;
                    u_late_key   = i_key;
                    if (r_late_lines != LATE_MAX) begin
                        u_late_lines = r_late_lines + 1'b1;
                    end
                end else begin
                    u_several_late = 1'b1;
                end
            end
        end
        late_in_table = KW'(u_late_key) < KW'(SUPP_KEYS);

        o_close.close      = i_last;
        o_close.cand       = i_final && u_lines == 2'd2 && u_several && u_late_valid
                             && !u_several_late && late_in_table;
        o_close.late_key   = u_late_key;
        o_close.late_lines = u_late_lines;

        n_first_valid  = r_first_valid;
        n_first_key    = r_first_key;
        n_several      = r_several;
        n_late_valid   = r_late_valid;
        n_late_key     = r_late_key;
        n_late_lines   = r_late_lines;
        n_several_late = r_several_late;
        n_lines        = r_lines;
        if (i_en) begin
            if (i_last) begin
                n_first_valid  = 1'b0;
                n_first_key    = '0;
                n_several      = 1'b0;
                n_late_valid   = 1'b0;
                n_late_key     = '0;
                n_late_lines   = '0;
                n_several_late = 1'b0;
                n_lines        = 2'd0;
            end else begin
                n_first_valid  = u_first_valid;
                n_first_key    = u_first_key;
                n_several      = u_several;
                n_late_valid   = u_late_valid;
                n_late_key     = u_late_key;
                n_late_lines   = u_late_lines;
                n_several_late = u_several_late;
                n_lines        = u_lines;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_valid  <= 1'b0;
            r_first_key    <= '0;
            r_several      <= 1'b0;
            r_late_valid   <= 1'b0;
            r_late_key     <= '0;
            r_late_lines   <= '0;
            r_several_late <= 1'b0;
            r_lines        <= 2'd0;
        end else begin
            r_first_valid  <= n_first_valid;
            r_first_key    <= n_first_key;
            r_several      <= n_several;
            r_late_valid   <= n_late_valid;
            r_late_key     <= n_late_key;
            r_late_lines   <= n_late_lines;
            r_several_late <= n_several_late;
            r_lines        <= n_lines;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/late_supplier_wait_counter.sv
// Top level of the late supplier wait counter: supplier table, sequencer and channels.
// Depends on lswc_pkg, lswc_chan_if and lswc_order.
//
// Usage: items arrive on i_item (supplier row, line item or count read) and each
// item gives exactly one result word on o_result. Configuration words arrive on
// i_cfg, which is always ready; index 0 sets the target nation and index 1 the
// largest supplier key. Configuration is to be written only while the block is idle;
// the block itself does not enforce this. Each item is handled as a read of its
// supplier table entry when the item is accepted, followed by the RMW state, which
// modifies the entry, writes it back and loads the result register. Because of the
// single-port table read-modify-write, no new item is accepted until the RMW state
// is over. The result stays in its register until taken; while it waits the
// block holds off the next item, but it takes a new item in the same cycle as the
// waiting result is taken. After reset the block clears the supplier table one entry
// a cycle and accepts no item until every entry is cleared.
`default_nettype none

module late_supplier_wait_counter #(
    parameter int SUPP_KEYS  = 16384,
    parameter int COUNT_BITS = 32
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    lswc_chan_if.sink   i_item,
    lswc_chan_if.source o_result,
    lswc_chan_if.sink   i_cfg
);
    import lswc_pkg::*;

    localparam int AW = (SUPP_KEYS > 1) ? $clog2(SUPP_KEYS) : 1;
    localparam int KW = ((AW > KEY_BITS) ? AW : KEY_BITS) + 1;
    localparam int MW = COUNT_BITS + 2;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RMW
    } t_state;

    t_state                 r_state;
    logic [AW-1:0]          r_clr_addr;
    logic [NATION_BITS-1:0] r_target_nation;
    logic [KEY_BITS-1:0]    r_max_key;
    logic [1:0]             r_func;
    logic                   r_in_table;
    logic                   r_nat_match;
    t_order_close           r_close;
    logic [AW-1:0]          r_addr;
    logic                   r_out_valid;
    t_out_word              r_out;
    logic [MW-1:0]          r_rd_data;
    logic [MW-1:0]          mem [SUPP_KEYS];

    t_in_word               item;
    t_cfg_word              cfg;
    t_order_close           close;
    logic                   can_take;
    logic                   acc;
    logic                   key_in_table;
    logic [KEY_BITS-1:0]    rd_key;
    logic                   rd_in_table;
    logic [AW-1:0]          rd_addr;
    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [MW-1:0]          mem_wdata;
    logic [COUNT_BITS-1:0]  cur_wait;
    logic [COUNT_BITS:0]    sum;
    logic [COUNT_BITS-1:0]  sat_wait;
    logic [63:0]            wait64;
    logic                   counted;
    t_out_word              n_out;

    assign item     = i_item.data;
    assign cfg      = i_cfg.data;
    assign can_take = r_state == ST_IDLE && (!r_out_valid || o_result.ready);
    assign acc      = can_take && i_item.valid;

    assign i_item.ready   = can_take;
    assign i_cfg.ready    = 1'b1;
    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_out;

    assign key_in_table = KW'(item.supp_key) < KW'(SUPP_KEYS);

    lswc_order #(
        .SUPP_KEYS (SUPP_KEYS)
    ) u_order (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (acc && item.func == FUNC_LINE),
        .i_key     (item.supp_key),
        .i_max_key (r_max_key),
        .i_commit  (item.commit_date),
        .i_receipt (item.receipt_date),
        .i_final   (item.order_final),
        .i_last    (item.last_line),
        .o_close   (close)
    );

    always_comb begin
        rd_key      = (item.func == FUNC_LINE) ? close.late_key : item.supp_key;
        rd_in_table = KW'(rd_key) < KW'(SUPP_KEYS);
        rd_addr     = AW'(rd_key);
    end

    always_comb begin
        cur_wait = r_rd_data[COUNT_BITS-1:0];
        sum      = {1'b0, cur_wait} + (COUNT_BITS + 1)'(r_close.late_lines);
        sat_wait = sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];
        wait64   = 64'(cur_wait);
        counted  = r_close.close && r_close.cand && r_rd_data[COUNT_BITS];

        n_out = '0;
        case (r_func)
            FUNC_LINE: begin
                n_out.order_done = r_close.close;
                if (counted) begin
                    n_out.order_counted = 1'b1;
                    n_out.late_supplier = r_close.late_key;
                    n_out.added_lines   = r_close.late_lines;
                end
            end
            FUNC_READ: begin
                if (r_in_table) begin
                    n_out.wait_count      = (|wait64[63:WAIT_BITS]) ? '1
                                                                    : wait64[WAIT_BITS-1:0];
                    n_out.supplier_listed = r_rd_data[COUNT_BITS+1] && cur_wait != '0;
                end
            end
            default: begin
                n_out = '0;
            end
        endcase

        mem_we    = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = r_rd_data;
        if (r_state == ST_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = '0;
        end else if (r_state == ST_RMW) begin
            if (r_func == FUNC_SUPPLIER && r_in_table) begin
                mem_we    = 1'b1;
                mem_wdata = {1'b1, r_rd_data[COUNT_BITS] | r_nat_match, cur_wait};
            end else if (r_func == FUNC_LINE && counted) begin
                mem_we    = 1'b1;
                mem_wdata = {r_rd_data[COUNT_BITS+1:COUNT_BITS], sat_wait};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && rd_in_table) begin
            r_rd_data <= mem[rd_addr];
        end
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_func      <= item.func;
            r_in_table  <= key_in_table;
            r_nat_match <= item.nation_key == r_target_nation;
            r_close     <= close;
            r_addr      <= rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_nation <= '0;
            r_max_key       <= MAX_KEY_RESET;
        end else if (i_cfg.valid) begin
            unique case (cfg.index)
                CFG_TARGET_NATION: r_target_nation <= cfg.data[NATION_BITS-1:0];
                CFG_MAX_SUPP_KEY:  r_max_key       <= cfg.data[KEY_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
            r_out       <= '0;
        end else begin
            if (r_state == ST_RMW) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == AW'(SUPP_KEYS - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (acc) begin
                        r_state <= ST_RMW;
                    end
                end
                ST_RMW: begin
                    r_out   <= n_out;
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: dv/testbench.sv
// Self-checking testbench for the late supplier wait counter.
// Drives supplier rows, line items and count reads, predicts every result word and
// compares it field by field. Depends on lswc_pkg, lswc_chan_if and the block.
`default_nettype none

module testbench;
    import lswc_pkg::*;

    localparam int SUPP_KEYS   = 16384;
    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 40;
    localparam int POOL_SIZE   = 6;
    localparam int LONG_LATE   = 258;
    localparam int HOLD_CYCLES = 300;
    localparam int MAX_PRINTS  = 40;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam logic [WAIT_BITS-1:0] WAIT_MAX = '1;

    typedef struct {
        t_in_word  w;
        bit        fixed;
        t_out_word r;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    lswc_chan_if #(.t_payload(t_in_word))  item_if ();
    lswc_chan_if #(.t_payload(t_out_word)) result_if ();
    lswc_chan_if #(.t_payload(t_cfg_word)) cfg_if ();

    late_supplier_wait_counter DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_if),
        .o_result (result_if),
        .i_cfg    (cfg_if)
    );

    // Own copy of the supplier table, the open order and the registers.
    bit                   known_supp  [SUPP_KEYS];
    bit                   target_supp [SUPP_KEYS];
    bit [WAIT_BITS-1:0]   wait_tally  [SUPP_KEYS];
    bit                   ord_first_valid;
    bit [KEY_BITS-1:0]    ord_first_key;
    bit                   ord_multi_supp;
    bit                   ord_late_valid;
    bit [KEY_BITS-1:0]    ord_late_key;
    bit [LATE_BITS-1:0]   ord_late_lines;
    bit                   ord_multi_late;
    bit [1:0]             ord_lines;
    bit [NATION_BITS-1:0] tgt_nation = '0;
    bit [KEY_BITS-1:0]    max_key    = MAX_KEY_RESET;

    t_out_word         due_results [$];
    t_row              dir_rows [$];
    logic [KEY_BITS-1:0] supp_pool [$];

    int mismatches    = 0;
    int items_sent    = 0;
    int closed_orders = 0;
    int counted_orders = 0;
    int cycle_count   = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int stall_left    = 0;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic t_in_word make_word(input logic [1:0] func, input logic [KEY_BITS-1:0] key,
                                           input logic [NATION_BITS-1:0] nation,
                                           input logic [DATE_BITS-1:0] commit,
                                           input logic [DATE_BITS-1:0] receipt,
                                           input logic fin, input logic last);
        t_in_word w;
        w.func         = func;
        w.supp_key     = key;
        w.nation_key   = nation;
        w.commit_date  = commit;
        w.receipt_date = receipt;
        w.order_final  = fin;
        w.last_line    = last;
        return w;
    endfunction

    function automatic t_out_word closed_word(input logic counted, input logic [KEY_BITS-1:0] key,
                                              input logic [LATE_BITS-1:0] lines);
        t_out_word r;
        r               = '0;
        r.order_done    = 1'b1;
        r.order_counted = counted;
        r.late_supplier = key;
        r.added_lines   = lines;
        return r;
    endfunction

    function automatic t_out_word read_word(input logic [WAIT_BITS-1:0] cnt, input logic listed);
        t_out_word r;
        r                 = '0;
        r.wait_count      = cnt;
        r.supplier_listed = listed;
        return r;
    endfunction

    function automatic void add_row(input t_in_word w, input bit fixed, input t_out_word r);
        t_row row;
        row.w     = w;
        row.fixed = fixed;
        row.r     = r;
        dir_rows.insert(dir_rows.size(), row);
    endfunction

    function automatic void clear_order();
        ord_first_valid = 1'b0;
        ord_first_key   = '0;
        ord_multi_supp  = 1'b0;
        ord_late_valid  = 1'b0;
        ord_late_key    = '0;
        ord_late_lines  = '0;
        ord_multi_late  = 1'b0;
        ord_lines       = '0;
    endfunction

    function automatic t_out_word tally_item(input t_in_word w);
        t_out_word          r;
        bit [WAIT_BITS-1:0] cur;
        r = '0;
        case (w.func)
            FUNC_SUPPLIER: begin
                known_supp[w.supp_key] = 1'b1;
                if (w.nation_key == tgt_nation) begin
                    target_supp[w.supp_key] = 1'b1;
                end
            end
            FUNC_LINE: begin
                if (ord_lines < 2) begin
                    ord_lines++;
                end
                if (w.supp_key <= max_key && !ord_multi_late) begin
                    if (!ord_first_valid) begin
                        ord_first_valid = 1'b1;
                        ord_first_key   = w.supp_key;
                    end else if (w.supp_key != ord_first_key) begin
                        ord_multi_supp = 1'b1;
                    end
                    if (w.receipt_date > w.commit_date) begin
                        if (!ord_late_valid || ord_late_key == w.supp_key) begin
                            ord_late_valid = 1'b1;
                            ord_late_key   = w.supp_key;
                            if (ord_late_lines != LATE_MAX) begin
                                ord_late_lines++;
                            end
                        end else begin
                            ord_multi_late = 1'b1;
                        end
                    end
                end
                if (w.last_line) begin
                    r.order_done = 1'b1;
                    closed_orders++;
                    if (w.order_final && ord_lines == 2 && ord_multi_supp && ord_late_valid &&
                        !ord_multi_late && target_supp[ord_late_key]) begin
                        cur = wait_tally[ord_late_key];
                        if (WAIT_MAX - cur < WAIT_BITS'(ord_late_lines)) begin
                            wait_tally[ord_late_key] = WAIT_MAX;
                        end else begin
                            wait_tally[ord_late_key] = cur + WAIT_BITS'(ord_late_lines);
                        end
                        r.order_counted = 1'b1;
                        r.late_supplier = ord_late_key;
                        r.added_lines   = ord_late_lines;
                        counted_orders++;
                    end
                    clear_order();
                end
            end
            FUNC_READ: begin
                cur               = wait_tally[w.supp_key];
                r.wait_count      = cur;
                r.supplier_listed = known_supp[w.supp_key] && cur != 0;
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    function automatic t_in_word random_line(input logic [KEY_BITS-1:0] k, input bit late,
                                             input bit fin, input bit last);
        int unsigned c;
        int unsigned r;
        if (late) begin
            c = $urandom_range(65534, 0);
            r = $urandom_range(65535, c + 1);
        end else begin
            r = $urandom_range(65535, 0);
            c = $urandom_range(65535, r);
        end
        return make_word(FUNC_LINE, k, NATION_BITS'($urandom), DATE_BITS'(c), DATE_BITS'(r),
                         fin, last);
    endfunction

    function automatic logic [KEY_BITS-1:0] pick_key();
        if ($urandom_range(0, 3) == 0 || supp_pool.size() == 0) begin
            return KEY_BITS'($urandom);
        end
        return supp_pool[$urandom_range(0, supp_pool.size() - 1)];
    endfunction

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        if (mismatches < MAX_PRINTS) begin
            $display("mismatch at cycle %0d, %s: got 0x%0h, expected 0x%0h",
                     cycle_count, what, got, want);
        end
        mismatches++;
    endtask

    task automatic push_item(input t_in_word w, input bit fixed, input t_out_word fixed_res);
        t_out_word pred;
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            item_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        item_if.valid <= 1'b1;
        item_if.data  <= w;
        @(posedge i_clk);
        while (item_if.ready !== 1'b1) @(posedge i_clk);
        pred = tally_item(w);
        due_results.insert(due_results.size(), fixed ? fixed_res : pred);
        items_sent++;
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        item_if.valid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= '{index: idx, data: val};
        @(posedge i_clk);
        while (cfg_if.ready !== 1'b1) @(posedge i_clk);
        case (idx)
            CFG_TARGET_NATION: tgt_nation = val[NATION_BITS-1:0];
            CFG_MAX_SUPP_KEY:  max_key    = val[KEY_BITS-1:0];
            default: begin
            end
        endcase
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic send_order();
        int                  n;
        logic [KEY_BITS-1:0] slow_key;
        logic [KEY_BITS-1:0] k;
        bit                  late;
        bit                  fin;
        bit                  last;
        n        = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 6);
        slow_key = supp_pool[$urandom_range(0, supp_pool.size() - 1)];
        for (int i = 0; i < n; i++) begin
            k    = supp_pool[$urandom_range(0, supp_pool.size() - 1)];
            late = (k == slow_key) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 11) == 0);
            last = (i == n - 1);
            fin  = last ? ($urandom_range(0, 4) != 0) : 1'($urandom_range(0, 1));
            push_item(random_line(k, late, fin, last), 1'b0, '0);
        end
    endtask

    task automatic run_phase();
        int                  quota_end;
        int                  pick;
        logic [KEY_BITS-1:0] k;
        supp_pool.delete();
        for (int i = 0; i < POOL_SIZE; i++) begin
            k = ($urandom_range(0, 3) == 0) ? KEY_BITS'($urandom)
                                            : KEY_BITS'($urandom_range(0, 63));
            supp_pool.insert(supp_pool.size(), k);
            push_item(make_word(FUNC_SUPPLIER, k,
                                ($urandom_range(0, 9) < 6) ? tgt_nation : NATION_BITS'($urandom),
                                DATE_BITS'($urandom), DATE_BITS'($urandom),
                                1'($urandom), 1'($urandom)), 1'b0, '0);
        end
        quota_end = items_sent + PHASE_ITEMS;
        while (items_sent < quota_end) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                send_order();
            end else if (pick < 78) begin
                push_item(make_word(FUNC_SUPPLIER, pick_key(), NATION_BITS'($urandom),
                                    DATE_BITS'($urandom), DATE_BITS'($urandom),
                                    1'($urandom), 1'($urandom)), 1'b0, '0);
            end else if (pick < 90) begin
                push_item(make_word(FUNC_READ, pick_key(), NATION_BITS'($urandom),
                                    DATE_BITS'($urandom), DATE_BITS'($urandom),
                                    1'($urandom), 1'($urandom)), 1'b0, '0);
            end else if (pick < 95) begin
                push_item(make_word(FUNC_UNUSED, KEY_BITS'($urandom), NATION_BITS'($urandom),
                                    DATE_BITS'($urandom), DATE_BITS'($urandom),
                                    1'($urandom), 1'($urandom)), 1'b0, '0);
            end else begin
                push_item(make_word(FUNC_LINE, pick_key(), NATION_BITS'($urandom),
                                    DATE_BITS'($urandom), DATE_BITS'($urandom),
                                    1'($urandom), 1'($urandom)), 1'b0, '0);
            end
        end
        foreach (supp_pool[i]) begin
            push_item(make_word(FUNC_READ, supp_pool[i], '0, '0, '0, 1'b0, 1'b0), 1'b0, '0);
        end
    endtask

    // The receiver, with an optional long hold-off requested by the stimulus.
    initial begin
        result_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                result_if.ready <= 1'b0;
                stall_left--;
            end else begin
                result_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_out_word got;
        t_out_word want;
        if (result_if.valid === 1'b1 && result_if.ready === 1'b1) begin
            got = result_if.data;
            if (due_results.size() == 0) begin
                flag_mismatch("result word with nothing due", '0, '0);
            end else begin
                want = due_results.pop_front();
                if (got.order_done !== want.order_done)
                    flag_mismatch("order_done", got.order_done, want.order_done);
                if (got.order_counted !== want.order_counted)
                    flag_mismatch("order_counted", got.order_counted, want.order_counted);
                if (got.late_supplier !== want.late_supplier)
                    flag_mismatch("late_supplier", got.late_supplier, want.late_supplier);
                if (got.added_lines !== want.added_lines)
                    flag_mismatch("added_lines", got.added_lines, want.added_lines);
                if (got.wait_count !== want.wait_count)
                    flag_mismatch("wait_count", got.wait_count, want.wait_count);
                if (got.supplier_listed !== want.supplier_listed)
                    flag_mismatch("supplier_listed", got.supplier_listed, want.supplier_listed);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles with %0d results due", cycle_count,
                     due_results.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        logic [CFG_DATA_BITS-1:0] nation_cfg [PHASES];
        logic [CFG_DATA_BITS-1:0] max_cfg    [PHASES];
        logic [KEY_BITS-1:0]      long_key;

        nation_cfg = '{16'h0000, 16'hFFFF, 16'h0003, 16'h0080, 16'h0011, 16'h0000};
        max_cfg    = '{16'h3FFF, 16'hFFFF, 16'd40,   16'd0,    16'h1FFF, 16'h3FFF};

        i_rst_n       = 1'b0;
        item_if.valid = 1'b0;
        item_if.data  = '0;
        cfg_if.valid  = 1'b0;
        cfg_if.data   = '0;
        clear_order();

        // Directed words under the reset settings: target nation 0, all keys in range.
        add_row(make_word(FUNC_READ, '0, '0, '0, '0, 1'b0, 1'b0), 1'b1, '0);
        add_row(make_word(FUNC_READ, '1, '0, '0, '0, 1'b0, 1'b0), 1'b1, '0);
        add_row(make_word(FUNC_UNUSED, '1, '1, '1, '1, 1'b1, 1'b1), 1'b1, '0);
        add_row(make_word(FUNC_SUPPLIER, 14'd5, 8'd0, '0, '0, 1'b0, 1'b0), 1'b1, '0);
        add_row(make_word(FUNC_SUPPLIER, '1, '1, '0, '0, 1'b0, 1'b0), 1'b1, '0);
        add_row(make_word(FUNC_SUPPLIER, 14'd5, 8'd7, '0, '0, 1'b0, 1'b0), 1'b1, '0);
        add_row(make_word(FUNC_LINE, 14'd5, '0, '0, '1, 1'b1, 1'b0), 1'b1, '0);
        add_row(make_word(FUNC_LINE, '1, '0, '1, '0, 1'b1, 1'b1), 1'b1,
                closed_word(1'b1, 14'd5, 8'd1));
        add_row(make_word(FUNC_READ, 14'd5, '0, '0, '0, 1'b0, 1'b0), 1'b1, read_word(32'd1, 1'b1));
        add_row(make_word(FUNC_LINE, 14'd5, '0, '0, '1, 1'b1, 1'b1), 1'b1,
                closed_word(1'b0, '0, '0));
        add_row(make_word(FUNC_LINE, 14'd5, '0, 16'd3, 16'd9, 1'b1, 1'b0), 1'b1, '0);
        add_row(make_word(FUNC_LINE, 14'd9, '0, 16'd9, 16'd3, 1'b0, 1'b1), 1'b1,
                closed_word(1'b0, '0, '0));
        add_row(make_word(FUNC_LINE, 14'd5, '0, 16'd3, 16'd9, 1'b1, 1'b0), 1'b1, '0);
        add_row(make_word(FUNC_LINE, '1, '0, 16'd0, 16'd1, 1'b1, 1'b1), 1'b1,
                closed_word(1'b0, '0, '0));
        add_row(make_word(FUNC_LINE, 14'd5, '0, 16'd100, 16'd100, 1'b1, 1'b0), 1'b1, '0);
        add_row(make_word(FUNC_LINE, 14'd9, '0, 16'd1, 16'd2, 1'b1, 1'b1), 1'b1,
                closed_word(1'b0, '0, '0));
        add_row(make_word(FUNC_LINE, 14'd5, '0, 16'd1, 16'd2, 1'b1, 1'b0), 1'b1, '0);
        add_row(make_word(FUNC_LINE, 14'd5, '0, 16'd1, 16'd2, 1'b1, 1'b1), 1'b1,
                closed_word(1'b0, '0, '0));
        add_row(make_word(FUNC_LINE, '1, '0, 16'd1, 16'd2, 1'b1, 1'b0), 1'b1, '0);
        add_row(make_word(FUNC_LINE, 14'd5, '0, 16'd2, 16'd1, 1'b1, 1'b1), 1'b1,
                closed_word(1'b0, '0, '0));
        add_row(make_word(FUNC_LINE, 14'd5, '0, 16'd4, 16'd8, 1'b0, 1'b0), 1'b0, '0);
        add_row(make_word(FUNC_LINE, 14'd5, '0, 16'd4, 16'd8, 1'b0, 1'b0), 1'b0, '0);
        add_row(make_word(FUNC_LINE, 14'd0, '0, 16'd10, 16'd5, 1'b1, 1'b1), 1'b0, '0);
        add_row(make_word(FUNC_READ, 14'd5, '0, '0, '0, 1'b0, 1'b0), 1'b0, '0);
        add_row(make_word(FUNC_READ, '1, '0, '0, '0, 1'b0, 1'b0), 1'b1, read_word('0, 1'b0));

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 24;
        recv_idle_pct = 84;
        foreach (dir_rows[i]) begin
            push_item(dir_rows[i].w, dir_rows[i].fixed, dir_rows[i].r);
        end
        drain_results();

        for (int p = 0; p < PHASES; p++) begin
            case (p / 2)
                0: begin
                    send_idle_pct = 24;
                    recv_idle_pct = 84;
                end
                1: begin
                    send_idle_pct = 84;
                    recv_idle_pct = 24;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            write_reg(CFG_TARGET_NATION, nation_cfg[p]);
            write_reg(CFG_MAX_SUPP_KEY, max_cfg[p]);
            if (p == 1) begin
                stall_left = HOLD_CYCLES;
            end
            run_phase();
            if (p == PHASES - 1) begin
                // One supplier late on more lines than the late-line counter holds.
                long_key = KEY_BITS'($urandom_range(0, 63));
                push_item(make_word(FUNC_SUPPLIER, long_key, tgt_nation, '0, '0, 1'b0, 1'b0),
                          1'b0, '0);
                for (int i = 0; i < LONG_LATE; i++) begin
                    push_item(random_line(long_key, 1'b1, 1'($urandom_range(0, 1)), 1'b0),
                              1'b0, '0);
                end
                push_item(random_line(long_key ^ 14'd1, 1'b0, 1'b1, 1'b1), 1'b0, '0);
                push_item(make_word(FUNC_READ, long_key, '0, '0, '0, 1'b0, 1'b0), 1'b0, '0);
            end
            drain_results();
        end

        repeat (8) @(posedge i_clk);
        $display("Sent %0d item words over %0d register settings; %0d orders closed, %0d counted.",
                 items_sent, PHASES + 1, closed_orders, counted_orders);
        $display("Idling swapped between sender and receiver, with one long receiver hold-off.");
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire
